// ===== sv/smseq_pkg.sv =====
// Shared types and constants for the stepper move sequencer.
// Used by smseq_div, stepper_move_sequencer and smseq_check; depends on nothing.
package smseq_pkg;

   // default widths for the top-level parameters
   localparam int POS_BITS_DEF    = 24;
   localparam int TIME_BITS_DEF   = 32;
   localparam int PERIOD_BITS_DEF = 16;

   // reset value of the homing step period register
   localparam int HOME_PERIOD_RESET = 1000;

   // item opcodes
   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_MOVE = 2'd1,
      OP_HOME = 2'd2,
      OP_LOAD = 2'd3
   } opcode_type;

   // motion phases as seen on the result word
   typedef enum logic [2:0] {
      PH_INIT   = 3'd0,
      PH_ACCEL  = 3'd1,
      PH_CRUISE = 3'd2,
      PH_DECEL  = 3'd3,
      PH_HOMING = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   // item sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_DIV  = 2'd2,
      ST_RESP = 2'd3
   } seq_state_type;

   // direction codes, two-bit signed
   localparam logic [1:0] DIR_IDLE = 2'b00;
   localparam logic [1:0] DIR_UP   = 2'b01;
   localparam logic [1:0] DIR_DOWN = 2'b11;

   // configuration register indexes
   localparam logic CSR_HOME_POSITION = 1'b0;
   localparam logic CSR_HOME_PERIOD   = 1'b1;

   // divider handshake
   typedef struct packed {
      logic start;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic int max2(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

// ===== sv/stepper_move_sequencer.sv =====
// Single-axis stepper move sequencer: command and tick words in, one status word out.
// Depends on smseq_pkg and smseq_div.
// An accepted word passes the EXEC state, then RESP with the status word; cruise ticks
// that check for a step wait in the DIV state while the divider forms elapsed_time /
// period a bit per cycle. One word in flight: no new word until the response is taken.
// Reset is synchronous: phase done, position 0, home position 0, home period 1000.
module stepper_move_sequencer #(
   parameter int POS_BITS    = smseq_pkg::POS_BITS_DEF,
   parameter int TIME_BITS   = smseq_pkg::TIME_BITS_DEF,
   parameter int PERIOD_BITS = smseq_pkg::PERIOD_BITS_DEF,
   localparam int REQ_DATA_BITS = ((POS_BITS + PERIOD_BITS + TIME_BITS + 3 + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((POS_BITS + 7 + 7) / 8) * 8,
   localparam int CSR_BITS      = smseq_pkg::max2(POS_BITS, PERIOD_BITS)
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // target_position, step_period, elapsed_time, limit_max_hit, limit_min_hit,
   // limit_home_hit
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // opcode, relative_move
   input  logic [2:0]               req_tuser,
   // response channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // step_pulse, step_direction, position, phase, done_res
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // configuration writes
   input  logic                     csr_we,
   input  logic                     csr_addr,
   input  logic [CSR_BITS-1:0]      csr_wdata
);

   localparam int SP_LO   = POS_BITS;
   localparam int EL_LO   = POS_BITS + PERIOD_BITS;
   localparam int LIM_LO  = EL_LO + TIME_BITS;
   localparam int CMP_BITS = smseq_pkg::max2(TIME_BITS, POS_BITS + 1);
   localparam int HCMP_BITS = smseq_pkg::max2(TIME_BITS, PERIOD_BITS);
   localparam logic [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
   localparam logic [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

   // sequencer state
   smseq_pkg::seq_state_type state_ff, state_in;

   // latched request word
   smseq_pkg::opcode_type  op_ff, op_in;
   logic [POS_BITS-1:0]    tp_ff, tp_in;
   logic [PERIOD_BITS-1:0] sp_ff, sp_in;
   logic                   rel_ff, rel_in;
   logic [TIME_BITS-1:0]   el_ff, el_in;
   logic                   lmax_ff, lmax_in;
   logic                   lmin_ff, lmin_in;
   logic                   lhome_ff, lhome_in;

   // axis state
   smseq_pkg::phase_type   phase_ff, phase_in;
   logic [POS_BITS-1:0]    cur_ff, cur_in;
   logic [POS_BITS-1:0]    start_ff, start_in;
   logic [POS_BITS-1:0]    target_ff, target_in;
   logic [1:0]             dir_ff, dir_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic                   pulse_ff, pulse_in;

   // configuration registers
   logic [POS_BITS-1:0]    home_pos_ff, home_pos_in;
   logic [PERIOD_BITS-1:0] home_per_ff, home_per_in;

   // divider link
   smseq_pkg::div_req_type  div_req;
   smseq_pkg::div_stat_type div_stat;
   logic [TIME_BITS-1:0]    quotient;

   // derived values
   logic [PERIOD_BITS-1:0] per_eff;
   logic                   step_ok;
   logic [POS_BITS-1:0]    cur_step;
   logic [POS_BITS:0]      rel_sum;
   logic [POS_BITS-1:0]    tgt_new;
   logic [POS_BITS:0]      move_diff;
   logic [POS_BITS:0]      home_diff;
   logic [1:0]             dir_move;
   logic [1:0]             dir_home;
   logic                   stop;
   logic [POS_BITS:0]      run_diff;
   logic [POS_BITS:0]      taken;
   logic                   quo_gt;
   logic                   home_gt;
   logic                   need_div;
   logic                   req_accept;

   smseq_div #(
      .TIME_BITS   (TIME_BITS),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .dividend (el_ff),
      .divisor  (per_eff),
      .div_stat (div_stat),
      .quotient (quotient)
   );

   assign req_accept = req_tvalid && req_tready;

   // step, target and direction arithmetic
   always_comb begin
      per_eff  = (period_ff == '0) ? PERIOD_BITS'(1) : period_ff;
      step_ok  = ((dir_ff == smseq_pkg::DIR_UP) && (cur_ff != POS_MAX)) ||
                 ((dir_ff == smseq_pkg::DIR_DOWN) && (cur_ff != POS_MIN));
      cur_step = cur_ff + {{(POS_BITS-2){dir_ff[1]}}, dir_ff};

      // relative target saturates to the position range
      rel_sum = {tp_ff[POS_BITS-1], tp_ff} + {cur_ff[POS_BITS-1], cur_ff};
      if (rel_sum[POS_BITS] != rel_sum[POS_BITS-1]) begin
         tgt_new = rel_sum[POS_BITS] ? POS_MIN : POS_MAX;
      end else begin
         tgt_new = rel_sum[POS_BITS-1:0];
      end
      if (!rel_ff) begin
         tgt_new = tp_ff;
      end

      move_diff = {tgt_new[POS_BITS-1], tgt_new} - {cur_ff[POS_BITS-1], cur_ff};
      home_diff = {home_pos_ff[POS_BITS-1], home_pos_ff} - {cur_ff[POS_BITS-1], cur_ff};
      dir_move  = (move_diff == '0) ? smseq_pkg::DIR_IDLE :
                  (move_diff[POS_BITS] ? smseq_pkg::DIR_DOWN : smseq_pkg::DIR_UP);
      dir_home  = (home_diff == '0) ? smseq_pkg::DIR_IDLE :
                  (home_diff[POS_BITS] ? smseq_pkg::DIR_DOWN : smseq_pkg::DIR_UP);

      stop = (cur_ff == target_ff) ||
             ((dir_ff == smseq_pkg::DIR_UP) && lmax_ff) ||
             ((dir_ff == smseq_pkg::DIR_DOWN) && lmin_ff);

      // steps taken since the move began
      run_diff = {cur_ff[POS_BITS-1], cur_ff} - {start_ff[POS_BITS-1], start_ff};
      taken    = run_diff[POS_BITS] ? (~run_diff + (POS_BITS+1)'(1)) : run_diff;
      quo_gt   = CMP_BITS'(quotient) > CMP_BITS'(taken);
      home_gt  = HCMP_BITS'(el_ff) > HCMP_BITS'(per_eff);

      need_div = (op_ff == smseq_pkg::OP_TICK) && (phase_ff == smseq_pkg::PH_CRUISE) && !stop;
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smseq_pkg::ST_IDLE: if (req_tvalid) state_in = smseq_pkg::ST_EXEC;
         smseq_pkg::ST_EXEC: state_in = need_div ? smseq_pkg::ST_DIV : smseq_pkg::ST_RESP;
         smseq_pkg::ST_DIV:  if (div_stat.done) state_in = smseq_pkg::ST_RESP;
         smseq_pkg::ST_RESP: if (rsp_tready) state_in = smseq_pkg::ST_IDLE;
         default:            state_in = smseq_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      div_req.start = 1'b0;
      unique case (state_ff)
         smseq_pkg::ST_IDLE: req_tready = 1'b1;
         smseq_pkg::ST_EXEC: div_req.start = need_div;
         smseq_pkg::ST_DIV:  ;
         smseq_pkg::ST_RESP: rsp_tvalid = 1'b1;
         default:            ;
      endcase
   end

   // request capture
   always_comb begin
      op_in    = op_ff;
      tp_in    = tp_ff;
      sp_in    = sp_ff;
      rel_in   = rel_ff;
      el_in    = el_ff;
      lmax_in  = lmax_ff;
      lmin_in  = lmin_ff;
      lhome_in = lhome_ff;
      if (req_accept) begin
         op_in    = smseq_pkg::opcode_type'(req_tuser[1:0]);
         rel_in   = req_tuser[2];
         tp_in    = req_tdata[POS_BITS-1:0];
         sp_in    = req_tdata[SP_LO +: PERIOD_BITS];
         el_in    = req_tdata[EL_LO +: TIME_BITS];
         lmax_in  = req_tdata[LIM_LO];
         lmin_in  = req_tdata[LIM_LO + 1];
         lhome_in = req_tdata[LIM_LO + 2];
      end
   end

   // axis state update
   always_comb begin
      phase_in  = phase_ff;
      cur_in    = cur_ff;
      start_in  = start_ff;
      target_in = target_ff;
      dir_in    = dir_ff;
      period_in = period_ff;
      pulse_in  = pulse_ff;
      if ((state_ff == smseq_pkg::ST_EXEC) && !need_div) begin
         pulse_in = 1'b0;
         unique case (op_ff)
            smseq_pkg::OP_MOVE: begin
               target_in = tgt_new;
               dir_in    = dir_move;
               start_in  = cur_ff;
               period_in = sp_ff;
               phase_in  = smseq_pkg::PH_INIT;
            end
            smseq_pkg::OP_HOME: begin
               period_in = home_per_ff;
               dir_in    = dir_home;
               phase_in  = smseq_pkg::PH_HOMING;
            end
            smseq_pkg::OP_LOAD: begin
               cur_in = tp_ff;
            end
            smseq_pkg::OP_TICK: begin
               case (phase_ff)
                  smseq_pkg::PH_INIT:   phase_in = smseq_pkg::PH_ACCEL;
                  smseq_pkg::PH_ACCEL:  phase_in = smseq_pkg::PH_CRUISE;
                  smseq_pkg::PH_CRUISE: phase_in = smseq_pkg::PH_DECEL;
                  smseq_pkg::PH_DECEL:  phase_in = smseq_pkg::PH_DONE;
                  smseq_pkg::PH_HOMING: begin
                     if (lhome_ff) begin
                        cur_in   = home_pos_ff;
                        phase_in = smseq_pkg::PH_DONE;
                     end else if (home_gt && step_ok) begin
                        cur_in   = cur_step;
                        pulse_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end else if ((state_ff == smseq_pkg::ST_DIV) && div_stat.done) begin
         // cruise step once the quotient is ready
         pulse_in = quo_gt && step_ok;
         if (quo_gt && step_ok) begin
            cur_in = cur_step;
         end
      end
   end

   // configuration writes
   always_comb begin
      home_pos_in = home_pos_ff;
      home_per_in = home_per_ff;
      if (csr_we) begin
         unique case (csr_addr)
            smseq_pkg::CSR_HOME_POSITION: home_pos_in = csr_wdata[POS_BITS-1:0];
            smseq_pkg::CSR_HOME_PERIOD:   home_per_in = csr_wdata[PERIOD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // control and axis registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= smseq_pkg::ST_IDLE;
         phase_ff    <= smseq_pkg::PH_DONE;
         cur_ff      <= '0;
         start_ff    <= '0;
         target_ff   <= '0;
         dir_ff      <= smseq_pkg::DIR_IDLE;
         period_ff   <= PERIOD_BITS'(1);
         pulse_ff    <= 1'b0;
         home_pos_ff <= '0;
         home_per_ff <= PERIOD_BITS'(smseq_pkg::HOME_PERIOD_RESET);
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         cur_ff      <= cur_in;
         start_ff    <= start_in;
         target_ff   <= target_in;
         dir_ff      <= dir_in;
         period_ff   <= period_in;
         pulse_ff    <= pulse_in;
         home_pos_ff <= home_pos_in;
         home_per_ff <= home_per_in;
      end
   end

   // request word registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      tp_ff    <= tp_in;
      sp_ff    <= sp_in;
      rel_ff   <= rel_in;
      el_ff    <= el_in;
      lmax_ff  <= lmax_in;
      lmin_ff  <= lmin_in;
      lhome_ff <= lhome_in;
   end

   // response word, direction reads idle once done
   always_comb begin
      logic       done_res;
      logic [1:0] dir_out;
      done_res  = (phase_ff == smseq_pkg::PH_DONE);
      dir_out   = done_res ? smseq_pkg::DIR_IDLE : dir_ff;
      rsp_tdata = RSP_DATA_BITS'({done_res, phase_ff, cur_ff, dir_out, pulse_ff});
   end

endmodule

// ===== sv/smseq_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on smseq_pkg for the handshake structs.
module smseq_div #(
   parameter int TIME_BITS   = smseq_pkg::TIME_BITS_DEF,
   parameter int PERIOD_BITS = smseq_pkg::PERIOD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  smseq_pkg::div_req_type   div_req,
   input  logic [TIME_BITS-1:0]     dividend,
   input  logic [PERIOD_BITS-1:0]   divisor,
   output smseq_pkg::div_stat_type  div_stat,
   output logic [TIME_BITS-1:0]     quotient
);

   localparam int CNT_BITS = $clog2(TIME_BITS + 1);

   logic [TIME_BITS-1:0]   quo_ff, quo_in;
   logic [PERIOD_BITS-1:0] rem_ff, rem_in;
   logic [PERIOD_BITS-1:0] dsr_ff, dsr_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [PERIOD_BITS:0]   shifted;
   logic                   fits;
   logic [PERIOD_BITS:0]   diff;

   // one subtract and compare per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[TIME_BITS-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      diff    = shifted - {1'b0, dsr_ff};
   end

   // iteration control and shift register update
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_BITS'(TIME_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[TIME_BITS-2:0], fits};
         rem_in = fits ? diff[PERIOD_BITS-1:0] : shifted[PERIOD_BITS-1:0];
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign quotient      = quo_ff;

endmodule

// ===== sv/smseq_check.sv =====
// Port-level checks for the stepper move sequencer, bound to the top level.
// Depends on smseq_pkg and stepper_move_sequencer.
module smseq_check #(
   parameter int POS_BITS    = smseq_pkg::POS_BITS_DEF,
   localparam int RSP_DATA_BITS = ((POS_BITS + 7 + 7) / 8) * 8
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int PH_LO   = POS_BITS + 3;
   localparam int DONE_AT = POS_BITS + 6;

   logic [2:0] rsp_phase;
   logic [1:0] rsp_dir;
   logic       rsp_done;

   assign rsp_phase = rsp_tdata[PH_LO +: 3];
   assign rsp_dir   = rsp_tdata[2:1];
   assign rsp_done  = rsp_tdata[DONE_AT];

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // one word in flight: no request taken while a response is pending
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request ready while a response is pending");

   // done flag agrees with the phase field
   a_done_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_done == (rsp_phase == smseq_pkg::PH_DONE)))
      else $error("done flag disagrees with phase");

   // direction reads idle once the move is done
   a_idle_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_done |-> (rsp_dir == smseq_pkg::DIR_IDLE))
      else $error("direction not idle in done phase");

   // after reset the block waits for a request
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule

bind stepper_move_sequencer smseq_check #(
   .POS_BITS    (POS_BITS)
) u_smseq_check (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
